### rtl/hfcd_pkg.sv
// hfcd_pkg: shared types, constants and the crc-8 step for the humidity frame decoder
// depends on nothing; used by the result channel interface, the core and the bench
package hfcd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // frame positions
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    // scaling, span over the full 16-bit raw range
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_TEMP_BAD = 2'd1,
        STAT_HUM_BAD  = 2'd2
    } status_t;

    // one byte through the crc-8, msb first
    function automatic logic [7:0] crc8_feed(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/hfcd_in_if.sv
// hfcd_in_if: byte channel into the decoder, valid/ready handshake
// depends on nothing
interface hfcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       first;

    modport source (output valid, output frame_byte, output first, input ready);
    modport sink   (input valid, input frame_byte, input first, output ready);
endinterface

### rtl/hfcd_out_if.sv
// hfcd_out_if: result channel out of the decoder, valid/ready handshake
// depends on hfcd_pkg for the status type
interface hfcd_out_if;
    import hfcd_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic [15:0]        temp_raw;
    logic [15:0]        hum_raw;
    status_t            status;

    modport source (output valid, output temp_centi, output hum_centi, output temp_raw,
                    output hum_raw, output status, input ready);
    modport sink   (input valid, input temp_centi, input hum_centi, input temp_raw,
                    input hum_raw, input status, output ready);
endinterface

### rtl/humidity_frame_crc_decoder_core.sv
// humidity_frame_crc_decoder_core: six-byte sensor frame decoder with crc-8 checks and scaling
// depends on hfcd_pkg, hfcd_in_if and hfcd_out_if
//
// usage
//   frame  : byte items in bus order: temp hi, temp lo, temp crc, hum hi, hum lo, hum crc;
//            first = 1 restarts the frame at the temperature high byte
//   result : one item per completed frame with raw words, scaled readings and status;
//            status reports a temperature crc mismatch ahead of a humidity one
// timing
//   one byte item is accepted per cycle while frame.ready is high; the crc-8 is folded in a whole byte at a time
//   after the sixth byte is accepted the result passes a frame register,
//   a register after the constant multipliers, then the output register where the
//   divide by 65535 is done as an add and shift
// reset
//   rst_n clears the frame position, crc (to 0xFF), words and all valid flags
// stall
//   while result.ready is low the pipeline fills and holds; frame.ready drops only once
//   every stage holds a result, and no item is lost or repeated
module humidity_frame_crc_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    hfcd_in_if.sink    frame,
    hfcd_out_if.source result
);
    import hfcd_pkg::*;

    // frame state
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] hum_word_reg, hum_word_next;
    logic        temp_bad_reg, temp_bad_next;

    // frame register: a completed frame waiting for the multipliers
    logic        fr_valid_reg;
    logic [15:0] fr_temp_reg, fr_hum_reg;
    status_t     fr_status_reg;

    // product register
    logic        pr_valid_reg;
    logic [30:0] pr_temp_reg;
    logic [29:0] pr_hum_reg;
    logic [15:0] pr_temp_raw_reg, pr_hum_raw_reg;
    status_t     pr_status_reg;

    // output register
    logic               out_valid_reg;
    logic signed [14:0] out_temp_reg;
    logic [13:0]        out_hum_reg;
    logic [15:0]        out_temp_raw_reg, out_hum_raw_reg;
    status_t            out_status_reg;

    logic        out_free, pr_free, fr_free;
    logic        accept;
    logic [2:0]  pos_eff;
    logic        frame_done;
    status_t     status_now;
    logic [31:0] t_sum;
    logic [30:0] h_sum;
    logic [14:0] t_q;
    logic [13:0] h_q;

    // each stage moves on when the one after it is empty or draining
    assign out_free = !out_valid_reg || result.ready;
    assign pr_free  = !pr_valid_reg || out_free;
    assign fr_free  = !fr_valid_reg || pr_free;

    assign frame.ready = fr_free;
    assign accept      = frame.valid && frame.ready;

    // a restart, or an unreachable position, takes the byte as the first one
    assign pos_eff = (frame.first || pos_reg > POS_HUM_CRC) ? POS_TEMP_HI : pos_reg;

    always_comb
    begin
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        temp_bad_next  = temp_bad_reg;
        pos_next       = pos_eff + 3'd1;
        frame_done     = 1'b0;
        unique case (pos_eff)
            POS_TEMP_HI:
            begin
                crc_next       = crc8_feed(CRC_INIT, frame.frame_byte);
                temp_word_next = {frame.frame_byte, temp_word_reg[7:0]};
            end
            POS_TEMP_LO:
            begin
                crc_next       = crc8_feed(crc_reg, frame.frame_byte);
                temp_word_next = {temp_word_reg[15:8], frame.frame_byte};
            end
            POS_TEMP_CRC:
            begin
                temp_bad_next = (crc_reg != frame.frame_byte);
                crc_next      = CRC_INIT;
            end
            POS_HUM_HI:
            begin
                crc_next      = crc8_feed(CRC_INIT, frame.frame_byte);
                hum_word_next = {frame.frame_byte, hum_word_reg[7:0]};
            end
            POS_HUM_LO:
            begin
                crc_next      = crc8_feed(crc_reg, frame.frame_byte);
                hum_word_next = {hum_word_reg[15:8], frame.frame_byte};
            end
            default:
            begin
                // humidity crc byte closes the frame
                pos_next   = POS_TEMP_HI;
                crc_next   = CRC_INIT;
                frame_done = 1'b1;
            end
        endcase
    end

    // temperature check wins over humidity
    always_comb
    begin
        priority if (temp_bad_reg)
        begin
            status_now = STAT_TEMP_BAD;
        end
        else if (crc_reg != frame.frame_byte)
        begin
            status_now = STAT_HUM_BAD;
        end
        else
        begin
            status_now = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_TEMP_HI;
            crc_reg       <= CRC_INIT;
            temp_word_reg <= '0;
            hum_word_reg  <= '0;
            temp_bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
            temp_bad_reg  <= temp_bad_next;
        end
    end

    // frame register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else if (fr_free)
        begin
            fr_valid_reg <= accept && frame_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && frame_done)
        begin
            fr_temp_reg   <= temp_word_reg;
            fr_hum_reg    <= hum_word_reg;
            fr_status_reg <= status_now;
        end
    end

    // constant multipliers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_valid_reg <= 1'b0;
        end
        else if (pr_free)
        begin
            pr_valid_reg <= fr_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pr_free && fr_valid_reg)
        begin
            pr_temp_reg     <= {16'd0, TEMP_SPAN} * {15'd0, fr_temp_reg};
            pr_hum_reg      <= {16'd0, HUM_SPAN} * {14'd0, fr_hum_reg};
            pr_temp_raw_reg <= fr_temp_reg;
            pr_hum_raw_reg  <= fr_hum_reg;
            pr_status_reg   <= fr_status_reg;
        end
    end

    // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for x below 65535 squared
    assign t_sum = 32'(pr_temp_reg) + 32'(pr_temp_reg >> 16) + 32'd1;
    assign h_sum = 31'(pr_hum_reg) + 31'(pr_hum_reg >> 16) + 31'd1;
    assign t_q   = t_sum[30:16];
    assign h_q   = h_sum[29:16];

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= pr_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && pr_valid_reg)
        begin
            out_temp_reg     <= $signed(t_q - TEMP_OFFSET);
            out_hum_reg      <= h_q;
            out_temp_raw_reg <= pr_temp_raw_reg;
            out_hum_raw_reg  <= pr_hum_raw_reg;
            out_status_reg   <= pr_status_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.temp_centi = out_temp_reg;
    assign result.hum_centi  = out_hum_reg;
    assign result.temp_raw   = out_temp_raw_reg;
    assign result.hum_raw    = out_hum_raw_reg;
    assign result.status     = out_status_reg;

    // checks
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_HUM_CRC)
        else $error("frame position out of range");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame.first) |=> (pos_reg == POS_TEMP_LO))
        else $error("restart did not move to second byte");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_hum_reg <= HUM_SPAN))
        else $error("humidity above full scale");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_temp_reg >= -15'sd4500 && out_temp_reg <= 15'sd13000))
        else $error("temperature out of range");

    a_frame_load: assert property (@(posedge clk) disable iff (!rst_n)
        (fr_free && !(accept && frame_done)) |=> !fr_valid_reg)
        else $error("frame register loaded without a closing byte");
endmodule

### tb/sv/humidity_frame_crc_decoder_core_tb.sv
// humidity_frame_crc_decoder_core_tb: self-checking bench for the six-byte sensor frame decoder
// depends on hfcd_pkg, hfcd_in_if, hfcd_out_if and humidity_frame_crc_decoder_core
// a scoreboard class predicts every frame result; plain tasks drive byte items with random gaps
`timescale 1ns / 1ps

module humidity_frame_crc_decoder_core_tb;
    import hfcd_pkg::*;

    // one decoded frame as it leaves the result channel
    typedef struct {
        logic signed [14:0] temp_centi;
        logic [13:0]        hum_centi;
        logic [15:0]        temp_raw;
        logic [15:0]        hum_raw;
        status_t            status;
    } reading_t;

    // tracks the frame position and crc exactly as the decoder should, and keeps
    // the readings that completed frames still owe on the result channel
    class frame_scoreboard;
        logic [2:0]  position  = POS_TEMP_HI;
        logic [7:0]  crc       = CRC_INIT;
        logic [15:0] temp_word = '0;
        logic [15:0] hum_word  = '0;
        logic        temp_bad  = 1'b0;
        reading_t    owed_readings[$];
        int unsigned mismatches   = 0;
        int unsigned bytes_seen   = 0;
        int unsigned readings_seen = 0;
        int unsigned status_count[3] = '{0, 0, 0};

        // crc-8, msb first, no reflection
        static function logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
            logic [7:0] c;
            c = acc ^ b;
            for (int k = 0; k < 8; k++)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
            return c;
        endfunction

        function int unsigned pending();
            return owed_readings.size();
        endfunction

        function void note_byte(input logic [7:0] b, input logic first_flag);
            logic [2:0]  p;
            logic [31:0] t_scaled;
            logic [31:0] h_scaled;
            logic signed [31:0] t_signed;
            reading_t    r;
            bytes_seen++;
            p = (first_flag || position > POS_HUM_CRC) ? POS_TEMP_HI : position;
            case (p)
                POS_TEMP_HI:
                begin
                    crc = crc_step(CRC_INIT, b);
                    temp_word[15:8] = b;
                end
                POS_TEMP_LO:
                begin
                    crc = crc_step(crc, b);
                    temp_word[7:0] = b;
                end
                POS_TEMP_CRC:
                begin
                    temp_bad = (crc != b);
                    crc = CRC_INIT;
                end
                POS_HUM_HI:
                begin
                    crc = crc_step(CRC_INIT, b);
                    hum_word[15:8] = b;
                end
                POS_HUM_LO:
                begin
                    crc = crc_step(crc, b);
                    hum_word[7:0] = b;
                end
                default:
                begin
                end
            endcase
            if (p != POS_HUM_CRC)
            begin
                position = p + 3'd1;
                return;
            end
            t_scaled = (32'd17500 * {16'd0, temp_word}) / 32'd65535;
            h_scaled = (32'd10000 * {16'd0, hum_word}) / 32'd65535;
            t_signed = $signed(t_scaled) - 32'sd4500;
            r.temp_centi = t_signed[14:0];
            r.hum_centi  = h_scaled[13:0];
            r.temp_raw   = temp_word;
            r.hum_raw    = hum_word;
            if (temp_bad)
                r.status = STAT_TEMP_BAD;
            else if (crc != b)
                r.status = STAT_HUM_BAD;
            else
                r.status = STAT_OK;
            owed_readings.push_back(r);
            position = POS_TEMP_HI;
            crc = CRC_INIT;
        endfunction

        function void field_mismatch(input string name, input int want, input int got);
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        endfunction

        function void check_result(input reading_t got);
            reading_t want;
            readings_seen++;
            if (owed_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, actual temp_raw %h hum_raw %h",
                         $time, got.temp_raw, got.hum_raw);
                return;
            end
            want = owed_readings.pop_front();
            if (int'(want.status) < 3)
                status_count[int'(want.status)]++;
            if (got.temp_centi !== want.temp_centi)
                field_mismatch("temp_centi", want.temp_centi, got.temp_centi);
            if (got.hum_centi !== want.hum_centi)
                field_mismatch("hum_centi", want.hum_centi, got.hum_centi);
            if (got.temp_raw !== want.temp_raw)
                field_mismatch("temp_raw", want.temp_raw, got.temp_raw);
            if (got.hum_raw !== want.hum_raw)
                field_mismatch("hum_raw", want.hum_raw, got.hum_raw);
            if (got.status !== want.status)
                field_mismatch("status", want.status, got.status);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hfcd_in_if  frame_ch ();
    hfcd_out_if result_ch ();

    humidity_frame_crc_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    frame_scoreboard sb;
    int unsigned     items_sent;
    logic            tx_calm;
    logic            rx_calm;

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // hard stop in case the decoder hangs or drops a result
    initial
    begin
        #2000000;
        $display("humidity_frame_crc_decoder_core_tb: errors");
        $finish;
    end

    // both channels are sampled on the clock edge itself, before any nonblocking
    // update of that edge lands, so driver and decoder ordering does not matter
    always @(posedge clk)
    begin
        reading_t got;
        if (rst_n && frame_ch.valid && frame_ch.ready)
            sb.note_byte(frame_ch.frame_byte, frame_ch.first);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.temp_centi = result_ch.temp_centi;
            got.hum_centi  = result_ch.hum_centi;
            got.temp_raw   = result_ch.temp_raw;
            got.hum_raw    = result_ch.hum_raw;
            got.status     = result_ch.status;
            sb.check_result(got);
        end
    end

    // result side: a random stall before each item, with calm stretches
    // where ready stays high
    initial
    begin
        int stall;
        rx_calm = 1'b0;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = ~rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // one byte item: optional idle gap, then hold valid until accepted;
    // valid is only lowered when a gap is actually taken
    task automatic send_byte(input logic [7:0] b, input logic first_flag);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.first      <= first_flag;
        do @(posedge clk); while (!frame_ch.ready);
        items_sent++;
    endtask

    // a frame in bus order; a bad crc byte is the good one with some bits flipped,
    // and a short byte count leaves the frame broken off
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input logic first_flag, input logic t_good, input logic h_good,
                              input int n_bytes);
        logic [7:0] bytes_out[6];
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = frame_scoreboard::crc_step(frame_scoreboard::crc_step(CRC_INIT, t_word[15:8]),
                                           t_word[7:0]);
        h_crc = frame_scoreboard::crc_step(frame_scoreboard::crc_step(CRC_INIT, h_word[15:8]),
                                           h_word[7:0]);
        if (!t_good)
            t_crc = t_crc ^ 8'($urandom_range(1, 255));
        if (!h_good)
            h_crc = h_crc ^ 8'($urandom_range(1, 255));
        bytes_out = '{t_word[15:8], t_word[7:0], t_crc, h_word[15:8], h_word[7:0], h_crc};
        for (int i = 0; i < n_bytes; i++)
            send_byte(bytes_out[i], (i == 0) ? first_flag : 1'b0);
    endtask

    // raw words lean toward the ends of the scale now and then
    function automatic logic [15:0] draw_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic wait_results_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int   kind;
        logic need_restart;
        logic drained_mid;
        sb = new;
        items_sent   = 0;
        tx_calm      = 1'b0;
        need_restart = 1'b0;
        drained_mid  = 1'b0;
        rst_n               <= 1'b0;
        frame_ch.valid      <= 1'b0;
        frame_ch.frame_byte <= 8'h00;
        frame_ch.first      <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lowest readings with good crcs, flagged start
        send_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 6);
        // highest readings, start flag missing at position zero, both crcs bad:
        // temperature status wins
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
        // frame broken off after two bytes, then restarted by the flag;
        // only the humidity crc is bad
        send_frame(16'h1234, 16'h5678, 1'b1, 1'b1, 1'b1, 2);
        send_frame(16'hFFFF, 16'h0001, 1'b1, 1'b1, 1'b0, 6);

        // random: mostly whole frames with random words and crc faults, plus
        // broken-off frames and loose noise bytes that force a restart
        while (items_sent < 1200)
        begin
            // one full pause midway: sender holds off until every result is back
            if (!drained_mid && items_sent >= 600)
            begin
                frame_ch.valid <= 1'b0;
                @(posedge clk);
                wait_results_drained();
                drained_mid = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                send_frame(draw_word(), draw_word(), need_restart | 1'($urandom_range(0, 1)),
                           $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, 6);
                need_restart = 1'b0;
            end
            else if (kind < 90)
            begin
                send_frame(draw_word(), draw_word(), need_restart | 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom_range(1, 5));
                need_restart = 1'b1;
            end
            else
            begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                need_restart = 1'b1;
            end
        end
        frame_ch.valid <= 1'b0;

        // drain, then keep the clock running past the three register stages to catch strays
        wait_results_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d byte items and %0d frame results", sb.bytes_seen, sb.readings_seen);
        $display("results by status: ok %0d, temperature crc bad %0d, humidity crc bad %0d",
                 sb.status_count[0], sb.status_count[1], sb.status_count[2]);
        if (sb.mismatches == 0)
            $display("humidity_frame_crc_decoder_core_tb: clean");
        else
            $display("humidity_frame_crc_decoder_core_tb: errors");
        $finish;
    end

endmodule

### files.f
rtl/hfcd_pkg.sv
rtl/hfcd_in_if.sv
rtl/hfcd_out_if.sv
rtl/humidity_frame_crc_decoder_core.sv
tb/sv/humidity_frame_crc_decoder_core_tb.sv
